// ----- rtl/tna_pkg.sv -----
// shared constants for the triangle normal and area pipeline
// no dependencies
`default_nettype none
package tna_pkg;
  localparam int COORD_W   = 16;  // default vertex coordinate width
  localparam int NORM_FRAC = 15;  // default normal fraction bits
  localparam int NORM_W    = 16;  // width of each normal component port
  localparam int AREA_W    = 33;  // width of the area port
endpackage
`default_nettype wire

// ----- rtl/tna_cross.sv -----
// edge vectors, products and cross product magnitude/sign, three stages
// depends on tna_pkg
`default_nettype none
module tna_cross #(
  parameter int CW = tna_pkg::COORD_W,
  localparam int EW = CW + 1,
  localparam int PW = 2 * EW
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic signed [CW-1:0] v0_x,
  input  wire logic signed [CW-1:0] v0_y,
  input  wire logic signed [CW-1:0] v0_z,
  input  wire logic signed [CW-1:0] v1_x,
  input  wire logic signed [CW-1:0] v1_y,
  input  wire logic signed [CW-1:0] v1_z,
  input  wire logic signed [CW-1:0] v2_x,
  input  wire logic signed [CW-1:0] v2_y,
  input  wire logic signed [CW-1:0] v2_z,
  output logic                      out_valid,
  output logic [2:0][PW-1:0]        out_mag,
  output logic [2:0]                out_neg
);
  localparam int XW = PW + 1;

  logic              vld_r [3];
  logic signed [EW-1:0] e_r [6];   // ux uy uz wx wy wz
  logic signed [PW-1:0] p_r [6];
  logic [2:0][PW-1:0]   mag_r;
  logic [2:0]           neg_r;
  logic signed [XW-1:0] c_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
      vld_r[1] <= 1'b0;
      vld_r[2] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  // stage 1: edges from the first vertex
  always_ff @(posedge clk) begin
    e_r[0] <= EW'(v1_x) - EW'(v0_x);
    e_r[1] <= EW'(v1_y) - EW'(v0_y);
    e_r[2] <= EW'(v1_z) - EW'(v0_z);
    e_r[3] <= EW'(v2_x) - EW'(v0_x);
    e_r[4] <= EW'(v2_y) - EW'(v0_y);
    e_r[5] <= EW'(v2_z) - EW'(v0_z);
  end

  // stage 2: the six partial products
  always_ff @(posedge clk) begin
    p_r[0] <= PW'(e_r[1]) * PW'(e_r[5]);
    p_r[1] <= PW'(e_r[2]) * PW'(e_r[4]);
    p_r[2] <= PW'(e_r[2]) * PW'(e_r[3]);
    p_r[3] <= PW'(e_r[0]) * PW'(e_r[5]);
    p_r[4] <= PW'(e_r[0]) * PW'(e_r[4]);
    p_r[5] <= PW'(e_r[1]) * PW'(e_r[3]);
  end

  // stage 3: differences, split into magnitude and sign
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = XW'(p_r[2*k]) - XW'(p_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      neg_r[k] <= c_nxt[k][XW-1];
      mag_r[k] <= c_nxt[k][XW-1] ? PW'(-c_nxt[k]) : PW'(c_nxt[k]);
    end
  end

  assign out_valid = vld_r[2];
  assign out_mag   = mag_r;
  assign out_neg   = neg_r;
endmodule
`default_nettype wire

// ----- rtl/tna_sqsum.sv -----
// sum of squares of three magnitudes, split-multiplier squaring, three stages
// depends on tna_pkg
`default_nettype none
module tna_sqsum #(
  parameter int MW  = 2 * (tna_pkg::COORD_W + 1),
  parameter int PLW = 8,
  localparam int SW = 2 * MW + 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [2:0][MW-1:0] in_mag,
  input  wire logic [PLW-1:0]     in_pl,
  output logic                    out_valid,
  output logic [SW-1:0]           out_sum,
  output logic [PLW-1:0]          out_pl
);
  localparam int H  = MW / 2;
  localparam int QW = 2 * MW;

  logic           vld_r [3];
  logic [PLW-1:0] pl_r  [3];
  logic [2*H-1:0] hh_r [3];
  logic [2*H-1:0] hl_r [3];
  logic [2*H-1:0] ll_r [3];
  logic [QW-1:0]  sq_r [3];
  logic [SW-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
      vld_r[1] <= 1'b0;
      vld_r[2] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    pl_r[0] <= in_pl;
    pl_r[1] <= pl_r[0];
    pl_r[2] <= pl_r[1];
  end

  // half-width partial products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      hh_r[k] <= (2*H)'(in_mag[k][MW-1:H]) * (2*H)'(in_mag[k][MW-1:H]);
      hl_r[k] <= (2*H)'(in_mag[k][MW-1:H]) * (2*H)'(in_mag[k][H-1:0]);
      ll_r[k] <= (2*H)'(in_mag[k][H-1:0])  * (2*H)'(in_mag[k][H-1:0]);
    end
  end

  // recombine into full squares
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= (QW'(hh_r[k]) << (2*H)) + (QW'(hl_r[k]) << (H+1)) + QW'(ll_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  assign out_valid = vld_r[2];
  assign out_sum   = sum_r;
  assign out_pl    = pl_r[2];
endmodule
`default_nettype wire

// ----- rtl/tna_isqrt.sv -----
// pipelined integer square root, two radicand bits per stage
// depends on tna_pkg
`default_nettype none
module tna_isqrt #(
  parameter int SW  = 4 * (tna_pkg::COORD_W + 1) + 2,
  parameter int PLW = 8,
  localparam int N  = SW / 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [SW-1:0]  in_rad,
  input  wire logic [PLW-1:0] in_pl,
  output logic                out_valid,
  output logic [N-1:0]        out_root,
  output logic [PLW-1:0]      out_pl
);
  logic           vld_r  [N];
  logic [PLW-1:0] pl_r   [N];
  logic [N+1:0]   rem_r  [N];
  logic [N-1:0]   root_r [N];
  logic [SW-1:0]  rad_r  [N];

  logic [N+1:0]   rem_src  [N];
  logic [N-1:0]   root_src [N];
  logic [SW-1:0]  rad_src  [N];
  logic [N+1:0]   rem_sh   [N];
  logic [N+1:0]   trial    [N];
  logic           ge       [N];

  always_comb begin
    rem_src[0]  = '0;
    root_src[0] = '0;
    rad_src[0]  = in_rad;
    for (int k = 1; k < N; k++) begin
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
      rad_src[k]  = rad_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      rem_sh[k] = {rem_src[k][N-1:0], rad_src[k][SW-1 -: 2]};
      trial[k]  = {root_src[k], 2'b01};
      ge[k]     = rem_sh[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    pl_r[0] <= in_pl;
    for (int k = 1; k < N; k++) pl_r[k] <= pl_r[k-1];
    for (int k = 0; k < N; k++) begin
      rem_r[k]  <= ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
      root_r[k] <= {root_src[k][N-2:0], ge[k]};
      rad_r[k]  <= rad_src[k] << 2;
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_pl    = pl_r[N-1];
endmodule
`default_nettype wire

// ----- rtl/tna_div.sv -----
// three-lane pipelined restoring divider, one quotient bit per stage
// depends on tna_pkg
`default_nettype none
module tna_div #(
  parameter int MW  = 2 * (tna_pkg::COORD_W + 1),
  parameter int LW  = MW + 1,
  parameter int F   = tna_pkg::NORM_FRAC,
  parameter int PLW = 8,
  localparam int NS = F + 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [2:0][MW-1:0] in_num,
  input  wire logic [LW-1:0]      in_den,
  input  wire logic [PLW-1:0]     in_pl,
  output logic                    out_valid,
  output logic [2:0][F:0]         out_quo,
  output logic [PLW-1:0]          out_pl
);
  localparam int RW = LW + 1;

  logic           vld_r [NS];
  logic [PLW-1:0] pl_r  [NS];
  logic [LW-1:0]  den_r [NS];
  logic [2:0][RW-1:0] rem_r [NS];
  logic [2:0][F:0]    quo_r [NS];

  logic [LW-1:0]      den_src [NS];
  logic [2:0][RW-1:0] rem_src [NS];
  logic [2:0][F:0]    quo_src [NS];
  logic [2:0][RW-1:0] rem_sh  [NS];
  logic [2:0]         ge      [NS];

  always_comb begin
    // first stage decides the integer bit directly on the numerator
    den_src[0] = in_den;
    quo_src[0] = '0;
    for (int j = 0; j < 3; j++) rem_sh[0][j] = RW'(in_num[j]);
    for (int k = 1; k < NS; k++) begin
      den_src[k] = den_r[k-1];
      quo_src[k] = quo_r[k-1];
      for (int j = 0; j < 3; j++) rem_sh[k][j] = rem_r[k-1][j] << 1;
    end
    for (int k = 0; k < NS; k++) begin
      rem_src[k] = rem_sh[k];
      for (int j = 0; j < 3; j++) ge[k][j] = rem_sh[k][j] >= RW'(den_src[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    pl_r[0] <= in_pl;
    for (int k = 1; k < NS; k++) pl_r[k] <= pl_r[k-1];
    for (int k = 0; k < NS; k++) begin
      den_r[k] <= den_src[k];
      for (int j = 0; j < 3; j++) begin
        rem_r[k][j] <= ge[k][j] ? rem_src[k][j] - RW'(den_src[k]) : rem_src[k][j];
        quo_r[k][j] <= {quo_src[k][j][F-1:0], ge[k][j]};
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_quo   = quo_r[NS-1];
  assign out_pl    = pl_r[NS-1];
endmodule
`default_nettype wire

// ----- rtl/triangle_normal_and_area.sv -----
// top level: triangle unit normal and area pipeline
// depends on tna_pkg, tna_cross, tna_sqsum, tna_isqrt, tna_div
`default_nettype none
// One triangle word is taken on every clock where start is high; busy is always
// low since the pipeline never stalls. Each word comes back exactly once, in
// order, with out_valid high for one cycle, after the cross product, squares,
// square root, divide and output register stages. The length is an exact
// integer square root, one root bit per stage; each normal component is a
// restoring divide by that length, one quotient bit per stage, truncated
// toward zero and saturated at +/-(2^F-1), where F = NORMAL_FRAC_BITS. A zero
// cross product reports a zero normal, zero area and sets out_degenerate. The
// receiver must take every word: there is no back pressure on the result side.
module triangle_normal_and_area #(
  parameter int COORD_WIDTH      = tna_pkg::COORD_W,
  parameter int NORMAL_FRAC_BITS = tna_pkg::NORM_FRAC
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_v0_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v0_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v0_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_z,
  output logic                               out_valid,
  output logic signed [tna_pkg::NORM_W-1:0]  out_normal_x,
  output logic signed [tna_pkg::NORM_W-1:0]  out_normal_y,
  output logic signed [tna_pkg::NORM_W-1:0]  out_normal_z,
  output logic [tna_pkg::AREA_W-1:0]         out_area,
  output logic                               out_degenerate
);
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int MW  = 2 * (COORD_WIDTH + 1);  // cross product magnitude
  localparam int SW  = 2 * MW + 2;             // sum of squares
  localparam int LW  = SW / 2;                 // root (length)
  localparam int AW  = tna_pkg::AREA_W;
  localparam int NW  = tna_pkg::NORM_W;
  localparam int XAW = LW + AW;                // room for the area clamp compare
  localparam int SPL = 3 * MW + 3;             // neg + mag
  localparam int RPL = SPL + 1;                // plus degenerate
  localparam int DPL = 3 + 1 + AW;             // neg, degenerate, area

  // no back pressure anywhere in the pipe
  assign busy = 1'b0;

  // cross product
  logic               cx_valid;
  logic [2:0][MW-1:0] cx_mag;
  logic [2:0]         cx_neg;

  tna_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .v0_x     (in_v0_x),
    .v0_y     (in_v0_y),
    .v0_z     (in_v0_z),
    .v1_x     (in_v1_x),
    .v1_y     (in_v1_y),
    .v1_z     (in_v1_z),
    .v2_x     (in_v2_x),
    .v2_y     (in_v2_y),
    .v2_z     (in_v2_z),
    .out_valid(cx_valid),
    .out_mag  (cx_mag),
    .out_neg  (cx_neg)
  );

  // squared length, magnitudes and signs ride along
  logic           sq_valid;
  logic [SW-1:0]  sq_sum;
  logic [SPL-1:0] sq_pl;

  tna_sqsum #(.MW(MW), .PLW(SPL)) u_sqsum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (cx_valid),
    .in_mag   (cx_mag),
    .in_pl    ({cx_neg, cx_mag}),
    .out_valid(sq_valid),
    .out_sum  (sq_sum),
    .out_pl   (sq_pl)
  );

  // length; degenerate flag is taken here on the exact sum
  logic           rt_valid;
  logic [LW-1:0]  rt_root;
  logic [RPL-1:0] rt_pl;

  tna_isqrt #(.SW(SW), .PLW(RPL)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_valid),
    .in_rad   (sq_sum),
    .in_pl    ({(sq_sum == '0), sq_pl}),
    .out_valid(rt_valid),
    .out_root (rt_root),
    .out_pl   (rt_pl)
  );

  logic               rt_deg;
  logic [2:0]         rt_neg;
  logic [2:0][MW-1:0] rt_mag;
  logic [XAW-1:0]     area_ext;
  logic [AW-1:0]      area_sat;

  assign rt_deg = rt_pl[RPL-1];
  assign rt_neg = rt_pl[SPL-1 -: 3];
  assign rt_mag = rt_pl[3*MW-1:0];

  // area = length/2, clamped to the port width
  always_comb begin
    area_ext = XAW'(rt_root >> 1);
    if (area_ext > XAW'({AW{1'b1}})) begin
      area_sat = {AW{1'b1}};
    end else begin
      area_sat = area_ext[AW-1:0];
    end
  end

  // normal components
  logic            dv_valid;
  logic [2:0][F:0] dv_quo;
  logic [DPL-1:0]  dv_pl;

  tna_div #(.MW(MW), .LW(LW), .F(F), .PLW(DPL)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rt_valid),
    .in_num   (rt_mag),
    .in_den   (rt_root),
    .in_pl    ({rt_neg, rt_deg, area_sat}),
    .out_valid(dv_valid),
    .out_quo  (dv_quo),
    .out_pl   (dv_pl)
  );

  logic [2:0]              dv_neg;
  logic                    dv_deg;
  logic [2:0][F-1:0]       qsat;
  logic signed [F:0]       qsgn [3];
  logic signed [NW-1:0]    nrm_nxt [3];
  logic                    out_valid_r;
  logic signed [NW-1:0]    nx_r, ny_r, nz_r;
  logic [AW-1:0]           area_r;
  logic                    deg_r;

  assign dv_neg = dv_pl[DPL-1 -: 3];
  assign dv_deg = dv_pl[AW];

  // saturate the full-scale quotient, apply sign, force zero when degenerate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qsat[j]    = dv_quo[j][F] ? {F{1'b1}} : dv_quo[j][F-1:0];
      qsgn[j]    = dv_neg[j] ? -$signed({1'b0, qsat[j]}) : $signed({1'b0, qsat[j]});
      nrm_nxt[j] = dv_deg ? '0 : NW'(qsgn[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    nx_r   <= nrm_nxt[0];
    ny_r   <= nrm_nxt[1];
    nz_r   <= nrm_nxt[2];
    area_r <= dv_deg ? '0 : dv_pl[AW-1:0];
    deg_r  <= dv_deg;
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nx_r;
  assign out_normal_y   = ny_r;
  assign out_normal_z   = nz_r;
  assign out_area       = area_r;
  assign out_degenerate = deg_r;
endmodule
`default_nettype wire
